// File: src/surface_block_light_interpolate_assert.svh
// Assertion macros shared by the light interpolation checker.
// Needs nothing but a clock, an active-low reset and the signals under test.
`ifndef SURFACE_BLOCK_LIGHT_INTERPOLATE_ASSERT_SVH
`define SURFACE_BLOCK_LIGHT_INTERPOLATE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLBI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slbi: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SLBI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slbi: next-cycle check failed");

`endif

// File: src/slbi_pkg.sv
// Shared types and constants for the surface block light interpolator.
// Used by slbi_core, surface_block_light_interpolate and the bench; no dependencies.
package slbi_pkg;

  localparam int unsigned MAX_BLOCK_SIDE_DEF = 16;
  localparam int unsigned LIGHT_W  = 16;
  localparam int unsigned CORNER_W = 14;
  localparam int unsigned TEXEL_W  = 8;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned MIP_W    = 2;
  localparam int unsigned ADDR_W   = 14;

  typedef struct packed {
    logic                block_start;
    logic [CORNER_W-1:0] corner_top_left;
    logic [CORNER_W-1:0] corner_top_right;
    logic [CORNER_W-1:0] corner_bottom_left;
    logic [CORNER_W-1:0] corner_bottom_right;
    logic [TEXEL_W-1:0]  texel;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] shade_address;
    logic [POS_W-1:0]  pixel_row;
    logic [POS_W-1:0]  pixel_column;
    logic              block_last;
  } result_t;

endpackage

// File: src/slbi_core.sv
// Light stepping datapath: edge/row light state, counters and address result.
// Depends on slbi_pkg; state advances when the owning stage hands on its beat.
module slbi_core #(
  parameter int unsigned MAX_BLOCK_SIDE = slbi_pkg::MAX_BLOCK_SIDE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [slbi_pkg::MIP_W-1:0]    mip_level,
  input  slbi_pkg::item_t               item,
  input  logic                          advance,
  output slbi_pkg::result_t             result
);

  localparam int unsigned LG    = $clog2(MAX_BLOCK_SIDE + 1) - 1;
  localparam int unsigned CNT_W = LG;
  localparam int unsigned SH_W  = $clog2(LG + 1);
  localparam int unsigned SW    = SH_W + 2;
  localparam int unsigned LW    = slbi_pkg::LIGHT_W;

  logic [LW-1:0]    left_light_r, left_light_nxt;
  logic [LW-1:0]    right_light_r, right_light_nxt;
  logic [LW-1:0]    left_step_r, left_step_nxt;
  logic [LW-1:0]    right_step_r, right_step_nxt;
  logic [LW-1:0]    run_light_r, run_light_nxt;
  logic [LW-1:0]    row_step_r, row_step_nxt;
  logic [CNT_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [CNT_W-1:0] col_cnt_r, col_cnt_nxt;

  logic [SH_W-1:0]  sh;
  logic [CNT_W-1:0] side_m1;
  logic [LW-1:0]    left_light_c, right_light_c, left_step_c, right_step_c;
  logic [LW-1:0]    run_light_c, row_step_c;
  logic [CNT_W-1:0] row_c, col_c, row_e, col_e;
  logic signed [LW-1:0] left_diff, right_diff;
  logic signed [LW:0]   row_diff;
  logic             row_end;

  always_comb begin
    if (SW'(LG) > SW'(mip_level)) begin
      sh = SH_W'(SW'(LG) - SW'(mip_level));
    end else begin
      sh = '0;
    end
    side_m1 = CNT_W'(((CNT_W + 1)'(1) << sh) - (CNT_W + 1)'(1));

    left_diff  = signed'(LW'(item.corner_bottom_left) - LW'(item.corner_top_left));
    right_diff = signed'(LW'(item.corner_bottom_right) - LW'(item.corner_top_right));

    // a block start replaces the edge state with the new corners
    if (item.block_start) begin
      left_light_c  = LW'(item.corner_top_left);
      right_light_c = LW'(item.corner_top_right);
      left_step_c   = LW'(left_diff >>> sh);
      right_step_c  = LW'(right_diff >>> sh);
      row_c         = '0;
      col_c         = '0;
    end else begin
      left_light_c  = left_light_r;
      right_light_c = right_light_r;
      left_step_c   = left_step_r;
      right_step_c  = right_step_r;
      row_c         = row_cnt_r;
      col_c         = col_cnt_r;
    end

    // drop counters left out of range by a mip change
    col_e = (col_c > side_m1) ? '0 : col_c;
    row_e = (row_c > side_m1) ? '0 : row_c;

    row_diff = signed'({left_light_c[LW-1], left_light_c})
             - signed'({right_light_c[LW-1], right_light_c});
    if (col_e == '0) begin
      run_light_c = right_light_c;
      row_step_c  = LW'(row_diff >>> sh);
    end else begin
      run_light_c = run_light_r;
      row_step_c  = row_step_r;
    end

    result.shade_address = {run_light_c[slbi_pkg::ADDR_W-1:8], item.texel};
    result.pixel_row     = slbi_pkg::POS_W'(row_e);
    result.pixel_column  = slbi_pkg::POS_W'(side_m1 - col_e);
    result.block_last    = (row_e == side_m1) && (col_e == side_m1);

    row_end         = (col_e == side_m1);
    run_light_nxt   = run_light_c + row_step_c;
    row_step_nxt    = row_step_c;
    left_step_nxt   = left_step_c;
    right_step_nxt  = right_step_c;
    if (row_end) begin
      col_cnt_nxt     = '0;
      left_light_nxt  = left_light_c + left_step_c;
      right_light_nxt = right_light_c + right_step_c;
      row_cnt_nxt     = (row_e == side_m1) ? '0 : row_e + CNT_W'(1);
    end else begin
      col_cnt_nxt     = col_e + CNT_W'(1);
      left_light_nxt  = left_light_c;
      right_light_nxt = right_light_c;
      row_cnt_nxt     = row_e;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_light_r  <= '0;
      right_light_r <= '0;
      left_step_r   <= '0;
      right_step_r  <= '0;
      run_light_r   <= '0;
      row_step_r    <= '0;
      row_cnt_r     <= '0;
      col_cnt_r     <= '0;
    end else if (advance) begin
      left_light_r  <= left_light_nxt;
      right_light_r <= right_light_nxt;
      left_step_r   <= left_step_nxt;
      right_step_r  <= right_step_nxt;
      run_light_r   <= run_light_nxt;
      row_step_r    <= row_step_nxt;
      row_cnt_r     <= row_cnt_nxt;
      col_cnt_r     <= col_cnt_nxt;
    end
  end

endmodule

// File: src/surface_block_light_interpolate.sv
// Top level of the surface block light interpolator: input register,
// slbi_core datapath, result register and the mip level register. Uses slbi_pkg.
//
//   channel | handshake          | payload
//   --------+--------------------+--------------------------------------------
//   cfg     | cfg_wr_en          | cfg_wr_data (mip level)
//   in      | in_valid/in_ready  | block_start, four corners, texel
//   out     | out_valid/out_ready| shade_address, pixel_row/column, block_last
//
// One texel per cycle sustained while out_ready is held high; an accepted beat
// passes through the input register, then the result register, to the output.
// Reset (rst_n low, synchronous) clears both valid flags, the mip level and
// all light state. A stalled output holds its beat; the input register, if empty,
// still takes a beat while the result register is full and drains behind it.
module surface_block_light_interpolate #(
  parameter int unsigned MAX_BLOCK_SIDE = slbi_pkg::MAX_BLOCK_SIDE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [slbi_pkg::MIP_W-1:0]        cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_block_start,
  input  logic [slbi_pkg::CORNER_W-1:0]     in_corner_top_left,
  input  logic [slbi_pkg::CORNER_W-1:0]     in_corner_top_right,
  input  logic [slbi_pkg::CORNER_W-1:0]     in_corner_bottom_left,
  input  logic [slbi_pkg::CORNER_W-1:0]     in_corner_bottom_right,
  input  logic [slbi_pkg::TEXEL_W-1:0]      in_texel,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [slbi_pkg::ADDR_W-1:0]       out_shade_address,
  output logic [slbi_pkg::POS_W-1:0]        out_pixel_row,
  output logic [slbi_pkg::POS_W-1:0]        out_pixel_column,
  output logic                              out_block_last
);

  logic [slbi_pkg::MIP_W-1:0] mip_level_r;
  logic                       s1_valid_r, s1_valid_nxt;
  slbi_pkg::item_t            s1_item_r;
  logic                       out_valid_r, out_valid_nxt;
  slbi_pkg::result_t          out_res_r;
  slbi_pkg::result_t          core_res;
  logic                       advance;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_comb begin
    s1_valid_nxt = in_ready ? in_valid : s1_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  slbi_core #(
    .MAX_BLOCK_SIDE (MAX_BLOCK_SIDE)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .mip_level (mip_level_r),
    .item      (s1_item_r),
    .advance   (advance),
    .result    (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mip_level_r <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mip_level_r <= cfg_wr_data;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.block_start         <= in_block_start;
      s1_item_r.corner_top_left     <= in_corner_top_left;
      s1_item_r.corner_top_right    <= in_corner_top_right;
      s1_item_r.corner_bottom_left  <= in_corner_bottom_left;
      s1_item_r.corner_bottom_right <= in_corner_bottom_right;
      s1_item_r.texel               <= in_texel;
    end
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_shade_address = out_res_r.shade_address;
  assign out_pixel_row     = out_res_r.pixel_row;
  assign out_pixel_column  = out_res_r.pixel_column;
  assign out_block_last    = out_res_r.block_last;

endmodule

// File: src/slbi_checker.sv
// Port-level checks for surface_block_light_interpolate, bound to the top.
// Uses the macros in surface_block_light_interpolate_assert.svh.
`include "surface_block_light_interpolate_assert.svh"

module slbi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [13:0] out_shade_address,
  input logic [3:0]  out_pixel_row,
  input logic [3:0]  out_pixel_column,
  input logic        out_block_last
);

  // a stalled result beat stays put
  `SLBI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_shade_address) && $stable(out_pixel_row) && $stable(out_pixel_column) && $stable(out_block_last))
  // the last pixel of a block is always the leftmost column
  `SLBI_ASSERT_NOW(a_last_col, clk, rst_n, out_valid && out_block_last, out_pixel_column == 4'd0)
  // input backpressure only comes from a full, stalled output
  `SLBI_ASSERT_NOW(a_no_bubble, clk, rst_n, !in_ready, out_valid && !out_ready)

endmodule

bind surface_block_light_interpolate slbi_checker u_slbi_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_shade_address (out_shade_address),
  .out_pixel_row     (out_pixel_row),
  .out_pixel_column  (out_pixel_column),
  .out_block_last    (out_block_last)
);

// File: bench/slbi_shade_check_pkg.sv
// Scoreboard for the surface block light interpolator bench: predicts each colormap
// address from the accepted texel beats and checks the result beats in order.
// Depends on slbi_pkg for the beat types.
package slbi_shade_check_pkg;
  import slbi_pkg::*;

  class shade_scoreboard;
    logic [MIP_W-1:0] mip;
    logic [15:0] left_light, right_light, left_step, right_step;
    logic [15:0] row_light, row_step;
    logic [4:0] row_idx, col_done;
    result_t pending_shades[$];
    int errors;
    int checked;

    function new();
      mip = '0;
      left_light = '0;
      right_light = '0;
      left_step = '0;
      right_step = '0;
      row_light = '0;
      row_step = '0;
      row_idx = '0;
      col_done = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_mip(logic [MIP_W-1:0] m);
      mip = m;
    endfunction

    function int pending();
      return pending_shades.size();
    endfunction

    // Advance the light state by one accepted texel and queue its address.
    function void predict_shade(item_t it);
      int unsigned sh;
      int unsigned side;
      int diff;
      logic [15:0] sum;
      result_t exp_beat;
      sh = 4 - mip;
      side = 1 << sh;
      if (it.block_start) begin
        left_light = 16'(it.corner_top_left);
        right_light = 16'(it.corner_top_right);
        left_step = 16'((int'(it.corner_bottom_left) - int'(it.corner_top_left)) >>> sh);
        right_step = 16'((int'(it.corner_bottom_right) - int'(it.corner_top_right)) >>> sh);
        row_idx = '0;
        col_done = '0;
      end
      // counters left over from a larger block size restart at zero
      if (col_done >= side) col_done = '0;
      if (row_idx >= side) row_idx = '0;
      if (col_done == 0) begin
        diff = int'($signed(left_light)) - int'($signed(right_light));
        row_light = right_light;
        row_step = 16'(diff >>> sh);
      end
      sum = {row_light[15:8], 8'h00} + 16'(it.texel);
      exp_beat.shade_address = sum[ADDR_W-1:0];
      exp_beat.pixel_row = row_idx[POS_W-1:0];
      exp_beat.pixel_column = 4'(side - 1 - col_done);
      exp_beat.block_last = (row_idx == side - 1) && (col_done == side - 1);
      pending_shades.push_back(exp_beat);

      row_light = row_light + row_step;
      col_done = col_done + 1;
      if (col_done >= side) begin
        col_done = '0;
        right_light = right_light + right_step;
        left_light = left_light + left_step;
        row_idx = row_idx + 1;
        if (row_idx >= side) row_idx = '0;
      end
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task check_shade(result_t got);
      result_t exp_beat;
      if (pending_shades.size() == 0) begin
        report($sformatf("result beat with nothing pending: %p", got));
      end else begin
        exp_beat = pending_shades.pop_front();
        checked++;
        if (got.shade_address !== exp_beat.shade_address)
          report($sformatf("shade_address %0h, want %0h", got.shade_address,
                           exp_beat.shade_address));
        if (got.pixel_row !== exp_beat.pixel_row)
          report($sformatf("pixel_row %0d, want %0d", got.pixel_row, exp_beat.pixel_row));
        if (got.pixel_column !== exp_beat.pixel_column)
          report($sformatf("pixel_column %0d, want %0d", got.pixel_column,
                           exp_beat.pixel_column));
        if (got.block_last !== exp_beat.block_last)
          report($sformatf("block_last %0b, want %0b", got.block_last, exp_beat.block_last));
      end
    endtask

    task check_drained();
      while (pending_shades.size() > 0) begin
        report($sformatf("beat never returned: %p", pending_shades.pop_front()));
      end
    endtask
  endclass

endpackage

// File: bench/surface_block_light_interpolate_test.sv
// Top of the light interpolator bench: clock, reset, drivers, monitors and stimulus.
// Depends on slbi_pkg, slbi_shade_check_pkg and the surface_block_light_interpolate RTL.
module surface_block_light_interpolate_test;
  timeunit 1ns;
  timeprecision 1ps;
  import slbi_pkg::*;
  import slbi_shade_check_pkg::*;

  localparam int TARGET_TEXELS = 1350;
  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [MIP_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ADDR_W-1:0] out_shade_address;
  logic [POS_W-1:0] out_pixel_row;
  logic [POS_W-1:0] out_pixel_column;
  logic out_block_last;
  result_t out_beat;

  bit send_gaps = 1'b0;
  bit recv_stalls = 1'b0;
  int ready_left = 0;
  int texels_sent = 0;
  int blocks_started = 0;
  int mip_writes = 0;
  shade_scoreboard sb = new();

  surface_block_light_interpolate dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_wr_data            (cfg_wr_data),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_block_start         (in_item.block_start),
    .in_corner_top_left     (in_item.corner_top_left),
    .in_corner_top_right    (in_item.corner_top_right),
    .in_corner_bottom_left  (in_item.corner_bottom_left),
    .in_corner_bottom_right (in_item.corner_bottom_right),
    .in_texel               (in_item.texel),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_shade_address      (out_shade_address),
    .out_pixel_row          (out_pixel_row),
    .out_pixel_column       (out_pixel_column),
    .out_block_last         (out_block_last)
  );

  assign out_beat = {out_shade_address, out_pixel_row, out_pixel_column, out_block_last};

  always #10 clk = ~clk;

  // Mostly short gaps, a few long ones.
  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function item_t make_item(bit s, int tl, int tr, int bl, int br, int tx);
    item_t it;
    it.block_start = s;
    it.corner_top_left = CORNER_W'(tl);
    it.corner_top_right = CORNER_W'(tr);
    it.corner_bottom_left = CORNER_W'(bl);
    it.corner_bottom_right = CORNER_W'(br);
    it.texel = TEXEL_W'(tx);
    return it;
  endfunction

  function int rand_corner();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 16383);
    return $urandom_range(64, 16320);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.predict_shade(in_item);
      texels_sent++;
      if (in_item.block_start) blocks_started++;
    end
    if (rst_n && out_valid && out_ready) sb.check_shade(out_beat);
  end

  // Receiver: toggle between ready runs and stalls, or stay ready in quiet stretches.
  always @(negedge clk) begin
    if (!recv_stalls) begin
      out_ready = 1'b1;
    end else if (ready_left > 0) begin
      ready_left--;
    end else begin
      out_ready = ~out_ready;
      ready_left = out_ready ? $urandom_range(0, 10) : gap_len();
    end
  end

  // Watchdog: end the run if no beat moves on either channel for too long.
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("surface_block_light_interpolate_test: errors");
    $finish;
  end

  task send_item(item_t it);
    int gap;
    gap = send_gaps ? gap_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_item = it;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold the sender until every pending beat has come back.
  task drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_mip(logic [MIP_W-1:0] m);
    drain();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = m;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.set_mip(m);
    mip_writes++;
  endtask

  task run_random_phase(int phase_no);
    logic [MIP_W-1:0] m;
    int side;
    int area;
    int count;
    int pos;
    bit s;
    m = (phase_no < 4) ? MIP_W'(3 - phase_no) : MIP_W'($urandom_range(0, 3));
    write_mip(m);
    send_gaps = ($urandom_range(0, 3) != 0);
    recv_stalls = ($urandom_range(0, 3) != 0);
    side = 16 >> m;
    area = side * side;
    count = $urandom_range(area / 2 + 1, area * 3);
    if (count > 300) count = $urandom_range(150, 300);
    // stop near the target item count
    if (count > TARGET_TEXELS - texels_sent) count = TARGET_TEXELS - texels_sent;
    if (count < 1) count = 1;
    // most phases open a fresh block; the rest continue whatever state is left
    pos = ($urandom_range(0, 9) < 7) ? 0 : 1;
    repeat (count) begin
      s = (pos == 0);
      if ($urandom_range(0, 99) < 3) s = ~s;
      if (s) pos = 0;
      pos = (pos + 1) % area;
      if ($urandom_range(0, 199) == 0) drain();
      send_item(make_item(s, rand_corner(), rand_corner(), rand_corner(), rand_corner(),
                          $urandom_range(0, 255)));
    end
  endtask

  initial begin
    int phase_no;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // texels with no block start run on the zero reset state
    recv_stalls = 1'b1;
    write_mip(2'd0);
    send_item(make_item(1'b0, 16383, 16383, 16383, 16383, 0));
    send_item(make_item(1'b0, 16383, 16383, 16383, 16383, 255));

    // smallest block: corner extremes, then wrap past the last texel
    write_mip(2'd3);
    send_item(make_item(1'b1, 64, 16320, 16320, 64, 255));
    send_item(make_item(1'b0, 0, 0, 0, 0, 0));
    send_item(make_item(1'b0, 0, 0, 0, 0, 8'hAA));
    send_item(make_item(1'b0, 0, 0, 0, 0, 8'h55));
    send_item(make_item(1'b0, 0, 0, 0, 0, 17));
    send_item(make_item(1'b0, 0, 0, 0, 0, 200));
    // corners outside the nominal range wrap
    send_item(make_item(1'b1, 16383, 0, 0, 16383, 1));
    send_item(make_item(1'b0, 0, 0, 0, 0, 254));
    send_item(make_item(1'b0, 0, 0, 0, 0, 128));
    send_item(make_item(1'b0, 0, 0, 0, 0, 127));

    // largest block, left part way along the first row
    write_mip(2'd0);
    send_item(make_item(1'b1, 16320, 64, 64, 16320, 3));
    repeat (9) send_item(make_item(1'b0, 0, 0, 0, 0, $urandom_range(0, 255)));

    // shrink the block mid-row so the column counter is stale
    write_mip(2'd2);
    repeat (3) send_item(make_item(1'b0, 0, 0, 0, 0, $urandom_range(0, 255)));

    phase_no = 0;
    while (texels_sent < TARGET_TEXELS) begin
      run_random_phase(phase_no);
      phase_no++;
    end

    drain();
    sb.check_drained();
    $display("run covered %0d texels, %0d block starts, %0d mip level writes",
             texels_sent, blocks_started, mip_writes);
    $display("%0d result beats checked, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("surface_block_light_interpolate_test: clean");
    end else begin
      $display("surface_block_light_interpolate_test: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/slbi_pkg.sv
src/slbi_core.sv
src/surface_block_light_interpolate.sv
src/slbi_checker.sv
bench/slbi_shade_check_pkg.sv
bench/surface_block_light_interpolate_test.sv
